// ===== hdl/ftc_pkg.sv =====
// Shared types and constants for the timestamp to clock fields converter.
`timescale 1ns / 1ps

package ftc_pkg;

  // Divisors used by the converter stages
  localparam int unsigned MS_PER_S      = 1000;
  localparam int unsigned S_PER_DAY     = 86400;
  localparam int unsigned S_PER_H       = 3600;
  localparam int unsigned S_PER_MIN     = 60;
  localparam int unsigned DAYS_PER_QUAD = 1461;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned MONTH_DIV     = 153;

  // Days from 1968-03-01 to 1970-01-01; quads of years start at 1968-03-01
  localparam logic [14:0] EPOCH_DAY_OFFSET = 15'd671;
  localparam logic [10:0] YEAR_BASE        = 11'd1968;

  // Every divider stage is three registers deep; five register groups in all
  localparam int unsigned DIV_LAT    = 3;
  localparam int unsigned PIPE_DEPTH = 4 * DIV_LAT + 1;

  // First day of each month in a March-based year (March is index 0)
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // One converted result
  typedef struct packed {
    logic       calendar_mode;
    logic [10:0] year_number;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [9:0]  hour_count;
    logic [5:0]  minute_count;
    logic [5:0]  second_count;
    logic [9:0]  milli_count;
  } ftc_result_t;

endpackage

// ===== hdl/ftc_cdiv.sv =====
// Three-stage divider by a constant: reciprocal multiply, back-multiply, one correction.
`timescale 1ns / 1ps

module ftc_cdiv #(
  parameter int unsigned X_W     = 31,
  parameter int unsigned DIVISOR = 1000,
  parameter int unsigned Q_W     = 22,
  parameter int unsigned R_W     = 10,
  parameter int unsigned SIDE_W  = 1
) (
  input  logic              clk,
  input  logic              en_i,
  input  logic [X_W-1:0]    x_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [Q_W-1:0]    q_o,
  output logic [R_W-1:0]    r_o,
  output logic [SIDE_W-1:0] side_o
);

  // floor(2^X_W / DIVISOR): estimate is exact or one short for any x below 2^X_W
  localparam logic [63:0]    RECIP_FULL = (64'd1 << X_W) / DIVISOR;
  localparam logic [X_W-1:0] RECIP      = RECIP_FULL[X_W-1:0];
  localparam logic [X_W-1:0] DIV_X      = X_W'(DIVISOR);

  logic [2*X_W-1:0]  prod_r, prod_nxt;
  logic [X_W-1:0]    x1_r, x2_r;
  logic [SIDE_W-1:0] side1_r, side2_r, side_r;
  logic [X_W-1:0]    q0_full;
  logic [2*X_W-1:0]  qd_full;
  logic [X_W-1:0]    qd_r, qd_nxt;
  logic [Q_W-1:0]    q0_r, q0_nxt;
  logic [X_W-1:0]    rem, rem_sub;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [R_W-1:0]    r_r, r_nxt;

  // stage 1: multiply by the reciprocal
  assign prod_nxt = (2*X_W)'(x_i) * (2*X_W)'(RECIP);

  // stage 2: quotient estimate and its back-product
  assign q0_full = prod_r[2*X_W-1 -: X_W];
  assign qd_full = (2*X_W)'(q0_full) * (2*X_W)'(DIV_X);
  assign qd_nxt  = qd_full[X_W-1:0];
  assign q0_nxt  = q0_full[Q_W-1:0];

  // stage 3: remainder below twice the divisor, fix up once
  assign rem     = x2_r - qd_r;
  assign rem_sub = rem - DIV_X;

  always_comb begin
    if (rem >= DIV_X) begin
      q_nxt = q0_r + Q_W'(1);
      r_nxt = rem_sub[R_W-1:0];
    end else begin
      q_nxt = q0_r;
      r_nxt = rem[R_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      prod_r  <= prod_nxt;
      x1_r    <= x_i;
      side1_r <= side_i;
      qd_r    <= qd_nxt;
      q0_r    <= q0_nxt;
      x2_r    <= x1_r;
      side2_r <= side1_r;
      q_r     <= q_nxt;
      r_r     <= r_nxt;
      side_r  <= side2_r;
    end
  end

  assign q_o    = q_r;
  assign r_o    = r_r;
  assign side_o = side_r;

endmodule

// ===== hdl/ftc_skid.sv =====
// Output skid buffer: holds one result so the pipeline never drives ready from the sink.
`timescale 1ns / 1ps

module ftc_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                last_valid_i,
  input  ftc_pkg::ftc_result_t last_data_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ftc_pkg::ftc_result_t out_data_o
);

  import ftc_pkg::*;

  logic        skid_valid_r, skid_valid_nxt;
  ftc_result_t skid_r;

  // skid fills when the last stage is shown but not taken
  always_comb begin
    if (skid_valid_r) begin
      skid_valid_nxt = !out_ready_i;
    end else begin
      skid_valid_nxt = last_valid_i && !out_ready_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid_r) begin
      skid_r <= last_data_i;
    end
  end

  // pipeline moves whenever the skid is empty
  assign advance_o   = !skid_valid_r;
  assign out_valid_o = skid_valid_r || last_valid_i;
  assign out_data_o  = skid_valid_r ? skid_r : last_data_i;

endmodule

// ===== hdl/flagged_timestamp_to_clock_fields_unit.sv =====
// Throughput: one transaction per cycle while the output skid is empty; each of the four
// constant-divider stages (ms or day split, hour split, minute split, month split) is fully pipelined.
// An output stall parks one result in the skid; input ready drops while it is full.
// Reset (synchronous, active low) clears the valid bits and the skid; data is not reset.
`timescale 1ns / 1ps

module flagged_timestamp_to_clock_fields_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // raw_stamp[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // year_number[10:0], month_number[14:11], day_of_month[19:15], hour_count[29:20],
  // minute_count[35:30], second_count[41:36], milli_count[51:42], zero [55:52]
  output logic [55:0] out_tdata,
  output logic        out_tuser   // calendar_mode
);

  import ftc_pkg::*;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] valid_r, valid_nxt;

  // stage A outputs
  logic [21:0] sec_a;
  logic [9:0]  milli_a;
  logic [14:0] days_a;
  logic [16:0] tod_a;
  logic        mode_ms_a, mode_day_a;
  // stage B outputs
  logic [9:0]  hour_b;
  logic [11:0] hrem_b;
  logic        mode_b;
  logic [4:0]  quad_b;
  logic [10:0] qrem_b;
  logic [9:0]  milli_b;
  // stage C outputs
  logic [5:0]  minute_c, second_c;
  logic [20:0] side_min_c;
  logic [2:0]  yq_c;
  logic [8:0]  yrem_c;
  logic [4:0]  quad_c;
  // stage D
  logic        wrap_c;
  logic [1:0]  yoq_c;
  logic [8:0]  doy_c;
  logic [10:0] mp_x;
  logic [48:0] side_mp_in, side_mp_d;
  logic [3:0]  mp_d;
  // stage E
  logic        mode_d;
  logic [9:0]  milli_d, hour_d;
  logic [5:0]  minute_d, second_d;
  logic [8:0]  doy_d;
  logic [1:0]  yoq_d;
  logic [4:0]  quad_d;
  logic [8:0]  dom_full;
  logic [3:0]  month_d;
  logic [10:0] year_d;
  ftc_result_t res_r, res_nxt, out_res;

  // valid bits travel alongside the data
  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = {valid_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage A: milliseconds to seconds, and epoch seconds to days; each carries a copy of the flag
  ftc_cdiv #(.X_W(31), .DIVISOR(MS_PER_S), .Q_W(22), .R_W(10), .SIDE_W(1)) u_div_ms (
    .clk(clk), .en_i(adv), .x_i(in_tdata[30:0]), .side_i(in_tdata[31]),
    .q_o(sec_a), .r_o(milli_a), .side_o(mode_ms_a)
  );

  ftc_cdiv #(.X_W(31), .DIVISOR(S_PER_DAY), .Q_W(15), .R_W(17), .SIDE_W(1)) u_div_day (
    .clk(clk), .en_i(adv), .x_i(in_tdata[30:0]), .side_i(in_tdata[31]),
    .q_o(days_a), .r_o(tod_a), .side_o(mode_day_a)
  );

  // stage B: hours from seconds or time of day; days into four-year quads
  ftc_cdiv #(.X_W(22), .DIVISOR(S_PER_H), .Q_W(10), .R_W(12), .SIDE_W(1)) u_div_h (
    .clk(clk), .en_i(adv), .x_i(mode_day_a ? 22'(tod_a) : sec_a), .side_i(mode_ms_a),
    .q_o(hour_b), .r_o(hrem_b), .side_o(mode_b)
  );

  ftc_cdiv #(.X_W(15), .DIVISOR(DAYS_PER_QUAD), .Q_W(5), .R_W(11), .SIDE_W(10)) u_div_quad (
    .clk(clk), .en_i(adv), .x_i(days_a + EPOCH_DAY_OFFSET), .side_i(milli_a),
    .q_o(quad_b), .r_o(qrem_b), .side_o(milli_b)
  );

  // stage C: minutes and seconds; year within the quad
  ftc_cdiv #(.X_W(12), .DIVISOR(S_PER_MIN), .Q_W(6), .R_W(6), .SIDE_W(21)) u_div_min (
    .clk(clk), .en_i(adv), .x_i(hrem_b), .side_i({mode_b, milli_b, hour_b}),
    .q_o(minute_c), .r_o(second_c), .side_o(side_min_c)
  );

  ftc_cdiv #(.X_W(11), .DIVISOR(DAYS_PER_YEAR), .Q_W(3), .R_W(9), .SIDE_W(5)) u_div_yr (
    .clk(clk), .en_i(adv), .x_i(qrem_b), .side_i(quad_b),
    .q_o(yq_c), .r_o(yrem_c), .side_o(quad_c)
  );

  // stage D: the leap day at the end of a quad stays in the fourth year
  assign wrap_c     = (yq_c == 3'd4);
  assign yoq_c      = wrap_c ? 2'd3 : yq_c[1:0];
  assign doy_c      = wrap_c ? 9'd365 : yrem_c;
  assign mp_x       = (11'(doy_c) << 2) + 11'(doy_c) + 11'd2;
  assign side_mp_in = {side_min_c, minute_c, second_c, doy_c, yoq_c, quad_c};

  ftc_cdiv #(.X_W(11), .DIVISOR(MONTH_DIV), .Q_W(4), .R_W(8), .SIDE_W(49)) u_div_mp (
    .clk(clk), .en_i(adv), .x_i(mp_x), .side_i(side_mp_in),
    .q_o(mp_d), .r_o(), .side_o(side_mp_d)
  );

  // stage E: month, day and year, then blank the fields the mode does not use
  assign {mode_d, milli_d, hour_d, minute_d, second_d, doy_d, yoq_d, quad_d} = side_mp_d;
  assign dom_full = doy_d - MONTH_START[mp_d] + 9'd1;
  assign month_d  = (mp_d < 4'd10) ? (mp_d + 4'd3) : (mp_d - 4'd9);
  assign year_d   = YEAR_BASE + {4'd0, quad_d, 2'b00} + {9'd0, yoq_d}
                    + {10'd0, (month_d <= 4'd2)};

  always_comb begin
    res_nxt.calendar_mode = mode_d;
    res_nxt.hour_count    = hour_d;
    res_nxt.minute_count  = minute_d;
    res_nxt.second_count  = second_d;
    if (mode_d) begin
      res_nxt.year_number  = year_d;
      res_nxt.month_number = month_d;
      res_nxt.day_of_month = dom_full[4:0];
      res_nxt.milli_count  = '0;
    end else begin
      res_nxt.year_number  = '0;
      res_nxt.month_number = '0;
      res_nxt.day_of_month = '0;
      res_nxt.milli_count  = milli_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  // output skid
  ftc_skid u_skid (
    .clk(clk), .rst_n(rst_n),
    .last_valid_i(valid_r[PIPE_DEPTH-1]), .last_data_i(res_r),
    .advance_o(adv),
    .out_valid_o(out_tvalid), .out_ready_i(out_tready), .out_data_o(out_res)
  );

  assign in_tready = adv;
  assign out_tuser = out_res.calendar_mode;
  assign out_tdata = {4'd0, out_res.milli_count, out_res.second_count, out_res.minute_count,
                      out_res.hour_count, out_res.day_of_month, out_res.month_number,
                      out_res.year_number};

endmodule

// ===== hdl/ftc_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps

module ftc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result stays offered with the same payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  // input ready only drops while a result is waiting at the output
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input blocked with no result offered");

  // uptime results: no date, fields in range
  a_uptime_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[19:0] == 20'd0 && out_tdata[35:30] < 6'd60
      && out_tdata[41:36] < 6'd60 && out_tdata[51:42] < 10'd1000)
    else $error("bad uptime result");

  // calendar results: no milliseconds, valid hour, month and day
  a_calendar_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[51:42] == 10'd0 && out_tdata[29:20] < 10'd24
      && out_tdata[14:11] >= 4'd1 && out_tdata[14:11] <= 4'd12 && out_tdata[19:15] != 5'd0)
    else $error("bad calendar result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind flagged_timestamp_to_clock_fields_unit ftc_checker u_ftc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
